// ===== src/vnfbm_pkg.sv =====
// Package for the value-noise fBm height unit: payload structs, hash constants,
// register indexes and reset values. No dependencies.
package vnfbm_pkg;

	localparam int CoordW = 32;
	localparam int FreqW = 16;
	localparam int GainW = 16;
	localparam int HeightW = 20;
	localparam int SumW = 16;
	localparam int CfgIdxW = 8;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] RegBaseFrequency = 8'd0;
	localparam logic [CfgIdxW-1:0] RegHeightGain = 8'd1;

	localparam logic [FreqW-1:0] BaseFrequencyReset = 16'd2294;
	localparam logic [GainW-1:0] HeightGainReset = 16'd2048;

	localparam logic [31:0] HashPrimeX = 32'd374761393;
	localparam logic [31:0] HashPrimeZ = 32'd668265263;
	localparam logic [31:0] HashMix = 32'd1274126177;
	localparam logic [HeightW-1:0] HeightMax = '1;

	typedef struct packed {
		logic signed [CoordW-1:0] coord_x;
		logic signed [CoordW-1:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic [HeightW-1:0] height;
		logic [SumW-1:0] noise_sum;
	} out_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [CfgDataW-1:0] data;
	} cfg_item_t;

endpackage

// ===== src/vnfbm_octave.sv =====
// One octave of value noise as a stall-controlled pipeline.
// Depends on vnfbm_pkg. en advances every stage at once.
module vnfbm_octave import vnfbm_pkg::*; #(
	parameter int FB = 16,
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CoordW-1:0] cx,
	input  logic signed [CoordW-1:0] cz,
	input  logic [FreqW-1:0] base_freq,
	output logic [FB-1:0] noise
);

	localparam int FW = FreqW + SHIFT + 1;
	localparam int PW = CoordW + FW;
	localparam logic [FB+2:0] ThreeOne = (FB+3)'(3) << FB;
	localparam logic [FB:0] One = (FB+1)'(1) << FB;

	// Stage 1: scale coordinates.
	logic signed [PW-1:0] px_s1, pz_s1;
	logic signed [FW-1:0] freq;
	assign freq = (FW'({1'b0, base_freq})) << SHIFT;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= PW'(cx) * freq;
			pz_s1 <= PW'(cz) * freq;
		end
	end

	// Stage 2: lattice cell, fraction, hash first mix, f*f.
	// The product is sign-extended so the cell index sees the full 64-bit value.
	logic signed [63:0] px_w, pz_w;
	assign px_w = 64'(px_s1);
	assign pz_w = 64'(pz_s1);

	logic [31:0] ix, iz, ix1, iz1;
	logic [FB-1:0] fx, fz;
	assign ix = px_w[63:32];
	assign iz = pz_w[63:32];
	assign ix1 = ix + 32'd1;
	assign iz1 = iz + 32'd1;
	assign fx = px_s1[31:32-FB];
	assign fz = pz_s1[31:32-FB];

	logic [31:0] hxa_s2, hxb_s2, hza_s2, hzb_s2;
	logic [FB-1:0] fx_s2, fz_s2;
	logic [2*FB-1:0] fx2_s2, fz2_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			hxa_s2 <= ix * HashPrimeX;
			hxb_s2 <= ix1 * HashPrimeX;
			hza_s2 <= iz * HashPrimeZ;
			hzb_s2 <= iz1 * HashPrimeZ;
			fx_s2 <= fx;
			fz_s2 <= fz;
			fx2_s2 <= fx * fx;
			fz2_s2 <= fz * fz;
		end
	end

	// Stage 3: corner sums and xorshift; smoothstep product.
	function automatic logic [31:0] xsh(input logic [31:0] h);
		return h ^ 32'($signed(h) >>> 13);
	endfunction

	logic [31:0] g_s3 [4];
	logic [FB:0] u_s3, v_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			g_s3[0] <= xsh(hxa_s2 + hza_s2);
			g_s3[1] <= xsh(hxb_s2 + hza_s2);
			g_s3[2] <= xsh(hxa_s2 + hzb_s2);
			g_s3[3] <= xsh(hxb_s2 + hzb_s2);
			u_s3 <= (FB+1)'(((3*FB+3)'(fx2_s2[2*FB-1:FB]) *
				(3*FB+3)'(ThreeOne - (FB+3)'({fx_s2, 1'b0}))) >> FB);
			v_s3 <= (FB+1)'(((3*FB+3)'(fz2_s2[2*FB-1:FB]) *
				(3*FB+3)'(ThreeOne - (FB+3)'({fz_s2, 1'b0}))) >> FB);
		end
	end

	// Stage 4: final hash multiply.
	logic [31:0] h_s4 [4];
	logic [FB:0] u_s4, v_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) h_s4[k] <= g_s3[k] * HashMix;
			u_s4 <= u_s3;
			v_s4 <= v_s3;
		end
	end

	// Stage 5: blend along x.
	logic [FB-1:0] c_val [4];
	always_comb begin
		for (int k = 0; k < 4; k++) c_val[k] = h_s4[k][30:31-FB];
	end

	function automatic logic [FB-1:0] lerp(input logic [FB-1:0] a, input logic [FB-1:0] b,
		input logic [FB:0] t);
		logic [2*FB+1:0] acc;
		acc = (2*FB+2)'(a) * (2*FB+2)'(One - t) + (2*FB+2)'(b) * (2*FB+2)'(t);
		return acc[2*FB-1:FB];
	endfunction

	logic [FB-1:0] ab_s5, cd_s5;
	logic [FB:0] v_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			ab_s5 <= lerp(c_val[0], c_val[1], u_s4);
			cd_s5 <= lerp(c_val[2], c_val[3], u_s4);
			v_s5 <= v_s4;
		end
	end

	// Stage 6: blend along z.
	always_ff @(posedge clk) begin
		if (en) noise <= lerp(ab_s5, cd_s5, v_s5);
	end

endmodule

// ===== src/value_noise_fbm_height_unit.sv =====
// Top level of the value-noise fBm height unit: config registers, octave
// pipelines, octave sum and gain stage. Depends on vnfbm_pkg and vnfbm_octave.
//
// Fully pipelined: OCTAVES octave lanes run in parallel, so one coordinate item
// enters per clock while no valid output is stalled. The pipeline stages are
// six octave stages, sum, gain multiply and saturate. When a valid output is
// stalled the whole pipeline holds; an empty output slot is filled anyway.
module value_noise_fbm_height_unit import vnfbm_pkg::*; #(
	parameter int OCTAVES = 4,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  cfg_item_t cfg_item
);

	localparam int FB = FRACTION_BITS;
	localparam int LAT = 9;
	localparam int AccW = FB + OCTAVES;

	logic [FreqW-1:0] base_freq_q;
	logic [GainW-1:0] gain_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q <= BaseFrequencyReset;
			gain_q <= HeightGainReset;
		end else if (cfg_valid) begin
			unique case (cfg_item.index)
				RegBaseFrequency: base_freq_q <= cfg_item.data;
				RegHeightGain: gain_q <= cfg_item.data;
				default: ;
			endcase
		end
	end

	// Pipeline advances unless a valid result is held by the consumer.
	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	logic [FB-1:0] oct_n [OCTAVES];
	for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
		vnfbm_octave #(.FB(FB), .SHIFT(i)) u_oct (
			.clk(clk), .en(en),
			.cx(in_item.coord_x), .cz(in_item.coord_z),
			.base_freq(base_freq_q), .noise(oct_n[i])
		);
	end

	// Stage 7: weighted octave sum to Q0.16.
	logic [AccW-1:0] acc;
	always_comb begin
		acc = '0;
		for (int i = 0; i < OCTAVES; i++)
			acc = acc + (AccW'(oct_n[i]) << (OCTAVES - 1 - i));
	end

	logic [FB-1:0] sum_fb;
	logic [SumW-1:0] q16;
	assign sum_fb = acc[AccW-1:OCTAVES];
	if (FB >= SumW) begin : g_q_dn
		assign q16 = SumW'(sum_fb >> (FB - SumW));
	end else begin : g_q_up
		assign q16 = SumW'({sum_fb, (SumW-FB)'(0)});
	end

	logic [SumW-1:0] sum_s7;
	always_ff @(posedge clk) begin
		if (en) sum_s7 <= q16;
	end

	// Stage 8: gain multiply.
	logic [SumW+GainW-1:0] prod_s8;
	logic [SumW-1:0] sum_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s8 <= sum_s7 * gain_q;
			sum_s8 <= sum_s7;
		end
	end

	// Stage 9: scale and saturate.
	logic [SumW+GainW-9:0] scaled;
	assign scaled = prod_s8[SumW+GainW-1:8];
	always_ff @(posedge clk) begin
		if (en) begin
			out_item.noise_sum <= sum_s8;
			out_item.height <= (scaled > (SumW+GainW-8)'(HeightMax)) ? HeightMax
				: HeightW'(scaled);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> $stable(vld_q) || !$past(out_valid))
		else $error("valid pipe moved under stall");

endmodule
